// File: rtl/hfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hfl_pkg;

  // Field widths of the request and response transactions
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  // Request modes
  localparam logic MODE_CREATE  = 1'b0;
  localparam logic MODE_DESTROY = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // Per-cycle move of a cell chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_UP   = 2'd1,
    CELL_DOWN = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     tail_load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/hfl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hfl_req_if;
  import hfl_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output mode, output handle, input ready);
  modport sink   (input valid, input mode, input handle, output ready);
endinterface

interface hfl_rsp_if;
  import hfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  active_total;

  modport source (output valid, output handle_out, output status, output active_total,
                  input ready);
  modport sink   (input valid, input handle_out, input status, input active_total,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/hfl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hfl_cell #(
  parameter int             W    = 4,
  parameter int             IW   = 4,
  parameter int             IDX  = 0,
  parameter logic [W-1:0]   INIT = '0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire hfl_pkg::cell_ctrl_t ctrl_i,
  input  wire  [IW-1:0]            tail_idx_i,
  input  wire  [W-1:0]             up_i,
  input  wire  [W-1:0]             down_i,
  input  wire  [W-1:0]             tail_i,
  output logic [W-1:0]             q_o
);
  import hfl_pkg::*;

  logic [W-1:0] val_d, val_q;

  // Select the next entry: hold, take from the neighbor below or above, or catch the head
  always_comb begin
    case (ctrl_i.op)
      CELL_HOLD: val_d = val_q;
      CELL_UP: begin
        if (ctrl_i.tail_load && (tail_idx_i == IW'(IDX))) begin
          val_d = tail_i;
        end else begin
          val_d = up_i;
        end
      end
      CELL_DOWN: val_d = down_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= INIT;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

// File: rtl/hfl_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module hfl_chain #(
  parameter int DEPTH   = 16,
  parameter int W       = 4,
  parameter bit DESCEND = 1'b0
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire hfl_pkg::cell_ctrl_t    ctrl_i,
  input  wire  [$clog2(DEPTH)-1:0]    tail_idx_i,
  input  wire  [W-1:0]                push_i,
  output logic [W-1:0]                head_o
);
  localparam int IW = $clog2(DEPTH);

  logic [W-1:0] val [DEPTH];

  // Build the row; cell 0 is the head, entries move one cell per cycle when the row shifts
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [W-1:0] INIT_K = DESCEND ? W'(DEPTH - 1 - k) : '0;
    logic [W-1:0] up_w, down_w;

    if (k == DEPTH - 1) begin : g_last
      assign up_w = val[k];
    end else begin : g_mid
      assign up_w = val[k+1];
    end

    if (k == 0) begin : g_first
      assign down_w = push_i;
    end else begin : g_rest
      assign down_w = val[k-1];
    end

    hfl_cell #(
      .W    (W),
      .IW   (IW),
      .IDX  (k),
      .INIT (INIT_K)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .tail_idx_i (tail_idx_i),
      .up_i       (up_w),
      .down_i     (down_w),
      .tail_i     (val[0]),
      .q_o        (val[k])
    );
  end

  assign head_o = val[0];

endmodule

`default_nettype wire

// File: rtl/body_handle_free_list_core.sv
// Fixed-capacity handle allocator. Handles 0 to CAPACITY-1 start on a LIFO free stack with the
// highest on top; a create transaction pops one and adds it to the active list, a destroy
// transaction looks it up and returns it to the free stack, answering full or absent when it
// cannot. Both lists are rows of CAPACITY cells that shift one place per cycle when they move.
// An accepted request is registered and the sequencer enters its work state. A create then
// commits into the output register once that register is free; a destroy first looks up the
// handle, rotating the active row one cell per cycle past the comparator at its head until it
// matches or has passed every active entry. One request is in work at a time; the next one is
// taken as soon as the current one has moved into the output register, even while that result
// still waits to be taken. With CAPACITY above 16, handles that need more than 4 bits are
// issued masked to 4 bits and can never be destroyed, and the active total is masked to 5 bits.
`timescale 1ns / 1ps
`default_nettype none

module body_handle_free_list_core #(
  parameter int CAPACITY = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  hfl_req_if.sink     req_i,
  hfl_rsp_if.source   rsp_o
);
  import hfl_pkg::*;

  localparam int HW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CW   = (HW > HANDLE_W) ? HW : HANDLE_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic                state_q, state_d;
  logic                mode_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CNTW-1:0]     act_cnt_q, act_cnt_d;
  logic [CNTW-1:0]     scan_q, scan_d;
  logic                out_v_q, out_v_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  logic [HW-1:0]       free_head, act_head;
  logic [HW-1:0]       free_push;
  logic [HW-1:0]       tail_idx;
  cell_ctrl_t          free_ctrl, act_ctrl;

  logic accept, out_free, is_create, full, scan_end, hit, finish, commit, step;

  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !out_v_q || rsp_o.ready;
  assign is_create = (mode_q == MODE_CREATE);
  assign full      = (act_cnt_q == CNTW'(CAPACITY));
  assign scan_end  = (scan_q == act_cnt_q);
  assign hit       = !is_create && !scan_end && (CW'(act_head) == CW'(handle_q));
  assign finish    = (state_q == S_WORK) && (is_create || scan_end || hit);
  assign commit    = finish && out_free;
  assign step      = (state_q == S_WORK) && !finish;
  assign tail_idx  = HW'(act_cnt_q - 1'b1);
  assign free_push = HW'(handle_q);

  // Drive both rows: pop/push the free stack, insert/rotate/drop on the active row
  always_comb begin
    free_ctrl = '{op: CELL_HOLD, tail_load: 1'b0};
    act_ctrl  = '{op: CELL_HOLD, tail_load: 1'b0};
    if (commit && is_create && !full) begin
      free_ctrl.op = CELL_UP;
      act_ctrl.op  = CELL_DOWN;
    end else if (commit && hit) begin
      free_ctrl.op = CELL_DOWN;
      act_ctrl.op  = CELL_UP;
    end else if (step) begin
      act_ctrl = '{op: CELL_UP, tail_load: 1'b1};
    end
  end

  hfl_chain #(
    .DEPTH   (CAPACITY),
    .W       (HW),
    .DESCEND (1'b1)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (free_ctrl),
    .tail_idx_i ('0),
    .push_i     (free_push),
    .head_o     (free_head)
  );

  hfl_chain #(
    .DEPTH   (CAPACITY),
    .W       (HW),
    .DESCEND (1'b0)
  ) u_active (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (act_ctrl),
    .tail_idx_i (tail_idx),
    .push_i     (free_head),
    .head_o     (act_head)
  );

  // Advance the sequencer, the active count and the scan position
  always_comb begin
    state_d   = state_q;
    act_cnt_d = act_cnt_q;
    scan_d    = scan_q;
    if (accept) begin
      state_d = S_WORK;
      scan_d  = '0;
    end else if (step) begin
      scan_d = scan_q + 1'b1;
    end else if (commit) begin
      state_d = S_IDLE;
      if (is_create && !full) begin
        act_cnt_d = act_cnt_q + 1'b1;
      end else if (hit) begin
        act_cnt_d = act_cnt_q - 1'b1;
      end
    end
  end

  // Load the output register on commit, drop it when taken
  always_comb begin
    out_v_d      = out_v_q;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    if (commit) begin
      out_v_d      = 1'b1;
      out_total_d  = TOTAL_W'(act_cnt_d);
      out_handle_d = handle_q;
      if (is_create) begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          out_status_d = ST_OK;
          out_handle_d = HANDLE_W'(free_head);
        end
      end else begin
        out_status_d = hit ? ST_OK : ST_ABSENT;
      end
    end else if (rsp_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_cnt_q <= '0;
      scan_q    <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_cnt_q <= act_cnt_d;
      scan_q    <= scan_d;
      out_v_q   <= out_v_d;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= req_i.mode;
      handle_q <= req_i.handle;
    end
    out_handle_q <= out_handle_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_v_q;
  assign rsp_o.handle_out   = out_handle_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.active_total = out_total_q;

  // The active count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_cnt_q <= CNTW'(CAPACITY))
    else $error("active count above capacity");

  // The lookup never runs past the active entries
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORK) |-> (scan_q <= act_cnt_q))
    else $error("scan position beyond active count");

  // A successful destroy shrinks the active row by one
  a_destroy_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && hit) |=> (act_cnt_q == $past(act_cnt_q) - 1'b1))
    else $error("destroy did not release an entry");

  // A new result appears only out of the work state
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == S_WORK))
    else $error("result raised without a request in work");

  // A pending result is never overwritten
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp_o.ready) |=> ($stable(out_handle_q) && $stable(out_status_q)
                                   && $stable(out_total_q)))
    else $error("pending result changed");

endmodule

`default_nettype wire

// File: tb/body_handle_free_list_core_test.sv
`timescale 1ns / 1ps

module body_handle_free_list_core_test;
  import hfl_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 220;
  localparam int DRAIN_TAIL  = 40;

  // One response as the allocator should produce it
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total;
  } reply_t;

  // Shadow of the free stack and active list plus the replies still owed
  class handle_pool_model;
    int     free_stack[CAPACITY];
    int     free_count;
    int     active_list[CAPACITY];
    int     active_count;
    reply_t owed_replies[$];
    int     errors;
    int     requests;
    int     ok_total;
    int     full_total;
    int     absent_total;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        free_stack[i]  = i;
        active_list[i] = 0;
      end
      free_count   = CAPACITY;
      active_count = 0;
      errors       = 0;
      requests     = 0;
      ok_total     = 0;
      full_total   = 0;
      absent_total = 0;
    endfunction

    // Work out the reply for an accepted request and advance the pool
    function void note_request(logic mode, logic [HANDLE_W-1:0] handle);
      reply_t r;
      int     hit;
      r.handle = handle;
      r.status = ST_OK;
      hit      = -1;
      if (mode == MODE_CREATE) begin
        if (free_count == 0 || active_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          free_count--;
          r.handle = HANDLE_W'(free_stack[free_count]);
          active_list[active_count] = free_stack[free_count];
          active_count++;
        end
      end else begin
        // first match wins; the last entry fills the hole
        for (int i = 0; i < active_count; i++) begin
          if (hit < 0 && active_list[i] == int'(handle)) hit = i;
        end
        if (hit >= 0 && free_count < CAPACITY) begin
          active_list[hit] = active_list[active_count - 1];
          active_count--;
          free_stack[free_count] = int'(handle);
          free_count++;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      r.total = TOTAL_W'(active_count);
      requests++;
      if (r.status == ST_OK) ok_total++;
      else if (r.status == ST_FULL) full_total++;
      else absent_total++;
      owed_replies.push_back(r);
    endfunction

    // Compare a taken response with the oldest owed reply
    function void check_reply(logic [HANDLE_W-1:0] handle, logic [STATUS_W-1:0] status,
                              logic [TOTAL_W-1:0] total);
      reply_t want;
      if (owed_replies.size() == 0) begin
        errors++;
        $display("%0t: response with none owed: handle %0d status %0d total %0d",
                 $time, handle, status, total);
        return;
      end
      want = owed_replies.pop_front();
      if (handle !== want.handle) begin
        errors++;
        $display("%0t: handle_out mismatch: expected %0d actual %0d",
                 $time, want.handle, handle);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
      end
      if (total !== want.total) begin
        errors++;
        $display("%0t: active_total mismatch: expected %0d actual %0d",
                 $time, want.total, total);
      end
    endfunction

    function logic [HANDLE_W-1:0] pick_active();
      return HANDLE_W'(active_list[$urandom_range(active_count - 1)]);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hfl_req_if req ();
  hfl_rsp_if rsp ();

  body_handle_free_list_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  handle_pool_model pool = new();

  int src_idle_pct;
  int rcv_stall_pct;
  int hold_left;
  int quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: check taken responses, then pick ready for the next cycle
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) begin
        pool.check_reply(rsp.handle_out, rsp.status, rsp.active_total);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("body_handle_free_list_core regression: fail");
        $finish;
      end
    end
  end

  // Offer one request, idling first at the current rate; valid stays high afterwards
  task automatic send_request(logic mode, logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.mode   <= mode;
    req.handle <= handle;
    do @(posedge clk_i); while (!req.ready);
    pool.note_request(mode, handle);
  endtask

  // Create or destroy by the given bias; a destroy mostly releases a live handle, sometimes a random one
  task automatic send_random(int create_pct);
    logic                mode;
    logic [HANDLE_W-1:0] handle;
    mode   = ($urandom_range(99) < create_pct) ? MODE_CREATE : MODE_DESTROY;
    handle = HANDLE_W'($urandom_range((1 << HANDLE_W) - 1));
    if (mode == MODE_DESTROY && pool.active_count > 0 && $urandom_range(9) < 8) begin
      handle = pool.pick_active();
    end
    send_request(mode, handle);
  endtask

  task automatic wait_drained();
    while (pool.owed_replies.size() != 0) @(posedge clk_i);
  endtask

  int src_pcts[4] = '{0, 76, 0, 10};
  int rcv_pcts[4] = '{0, 0, 76, 10};
  int fill_bias[3] = '{15, 50, 85};

  // Main sequence
  initial begin
    int create_pct;
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    create_pct    = 50;
    rst_ni     <= 1'b0;
    req.valid  <= 1'b0;
    req.mode   <= MODE_CREATE;
    req.handle <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the pool, then one create past full
    for (int i = 0; i < CAPACITY; i++) send_request(MODE_CREATE, HANDLE_W'(i));
    send_request(MODE_CREATE, 4'hA);
    // Release at the far end and then at the head of the active list, then a stale handle
    send_request(MODE_DESTROY, 4'hF);
    send_request(MODE_DESTROY, 4'h0);
    send_request(MODE_DESTROY, 4'h0);
    send_request(MODE_CREATE, 4'h5);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_pcts[p];
      rcv_stall_pct = rcv_pcts[p];
      // Back up the block behind a stalled receiver
      if (p == 0) hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) create_pct = fill_bias[$urandom_range(2)];
        send_random(create_pct);
      end
      // Let everything come out before the next phase
      if (p == 1) begin
        req.valid <= 1'b0;
        wait_drained();
      end
    end

    req.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("Ran %0d requests (%0d ok, %0d full, %0d absent) through four flow-control phases",
             pool.requests, pool.ok_total, pool.full_total, pool.absent_total);
    $display("including a %0d-cycle receiver hold-off and a full drain between phases",
             HOLD_CYCLES);
    if (pool.errors == 0) begin
      $display("body_handle_free_list_core regression: pass");
    end else begin
      $display("body_handle_free_list_core regression: fail");
    end
    $finish;
  end

endmodule
